/* rtl/vdtd_pkg.sv */
// vdtd_pkg: shared types, constants and helper functions of the varint datetime decoder
// no dependencies; imported by varint_datetime_decoder_unit and vdtd_checker

package vdtd_pkg;

    localparam int MAX_VALUES       = 7;
    localparam int MAX_VARINT_BYTES = 10;
    localparam int NUM_TERMS        = 5;
    localparam int TDATA_OUT_W      = 104;

    localparam logic [7:0] CONT_BIT     = 8'h80;
    localparam logic [6:0] PAYLOAD_MASK = 7'h7f;

    // floor(u / 100) as (u * RECIP_100) >> RECIP_SHIFT, exact for u below 2^17
    localparam logic [17:0] RECIP_100   = 18'd167773;
    localparam int          RECIP_SHIFT = 24;
    localparam logic [16:0] YEAR_BIAS   = 17'd32800;
    localparam logic [10:0] CENT_BIAS   = 11'd328;
    localparam logic signed [31:0] EPOCH_DAYS = 32'sd719468;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_BAD_MONTH = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV    = 6'b000010,
        ST_DAYS   = 6'b000100,
        ST_LOAD   = 6'b001000,
        ST_STEP   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    // microseconds per unit of each product term: days, hours, minutes, seconds, microseconds
    function automatic logic [36:0] term_scale(input logic [2:0] idx);
        logic [36:0] k;
        case (idx)
            3'd0:    k = 37'd86400000000;
            3'd1:    k = 37'd3600000000;
            3'd2:    k = 37'd60000000;
            3'd3:    k = 37'd1000000;
            3'd4:    k = 37'd1;
            default: k = 37'd0;
        endcase
        return k;
    endfunction

    // days from march 1 to the first of the month
    function automatic logic [8:0] month_doy(input logic [7:0] m);
        logic [8:0] d;
        case (m)
            8'd3:    d = 9'd0;
            8'd4:    d = 9'd31;
            8'd5:    d = 9'd61;
            8'd6:    d = 9'd92;
            8'd7:    d = 9'd122;
            8'd8:    d = 9'd153;
            8'd9:    d = 9'd184;
            8'd10:   d = 9'd214;
            8'd11:   d = 9'd245;
            8'd12:   d = 9'd275;
            8'd1:    d = 9'd306;
            8'd2:    d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/varint_datetime_decoder_unit.sv */
// varint_datetime_decoder_unit: splits a raw datetime byte stream into base-128 varints
// and converts the kept values to epoch microseconds with one shared shift-add unit
// depends on vdtd_pkg
// timing: non-final bytes are absorbed in the cycle of their transfer, one byte per cycle
// final byte: ST_DIV and ST_DAYS, then per term ST_LOAD and the 64-bit shift-add multiply-accumulate
// in ST_STEP, one bit of its time scale per step, then ST_FINISH; on an error status ST_DIV goes to ST_FINISH
// throughput: s_axis_tready is low from the final byte until the result is in the output register
// reset: aresetn low at a clock edge clears decode state, sequencer and m_axis_tvalid

module varint_datetime_decoder_unit
    import vdtd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // raw_byte[7:0]
    input  logic                   s_axis_tlast,  // end_of_value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // year_out[15:0], month_out[23:16], day_out[31:24], value_count[34:32],
    // epoch_microseconds[98:35], status[100:99], zero pad[103:101]
    output logic [TDATA_OUT_W-1:0] m_axis_tdata
);

    state_t              state_reg, state_next;
    logic [63:0]         acc_reg, acc_next;
    logic [3:0]          biv_reg, biv_next;
    logic [2:0]          seen_reg, seen_next;
    logic [15:0]         yr_reg, yr_next;
    logic [7:0]          mo_reg, mo_next;
    logic [7:0]          dy_reg, dy_next;
    logic [63:0]         tv_reg [4];
    logic [63:0]         tv_next [4];
    logic signed [16:0]  yy_reg, yy_next;
    logic signed [10:0]  cent_reg, cent_next;
    status_t             status_reg, status_next;
    logic [2:0]          term_reg, term_next;
    logic [63:0]         mcand_reg, mcand_next;
    logic [36:0]         scale_reg, scale_next;
    logic [63:0]         ep_reg, ep_next;
    logic                mvalid_reg, mvalid_next;
    logic [TDATA_OUT_W-1:0] mdata_reg, mdata_next;

    logic                s_xfer;
    logic [6:0]          shamt;
    logic [63:0]         acc_or;
    logic                close_val;
    logic [16:0]         yy_bias;
    logic [34:0]         recip_prod;
    logic signed [31:0]  days;
    logic [63:0]         term_mcand;
    logic                out_free;
    logic [15:0]         yr_o;
    logic [7:0]          mo_o;
    logic [7:0]          dy_o;
    logic [16:0]         yy_calc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign out_free      = !mvalid_reg || m_axis_tready;

    assign shamt     = {biv_reg, 3'b000} - {3'b000, biv_reg};
    assign acc_or    = acc_reg | ({57'd0, s_axis_tdata[6:0] & PAYLOAD_MASK} << shamt);
    assign close_val = ((s_axis_tdata & CONT_BIT) == 8'd0) || s_axis_tlast
                       || (biv_reg == 4'(MAX_VARINT_BYTES - 1));

    assign yy_calc    = {yr_reg[15], yr_reg} - ((mo_reg <= 8'd2) ? 17'd1 : 17'd0);
    assign yy_bias    = yy_calc + YEAR_BIAS;
    assign recip_prod = {18'd0, yy_bias} * {17'd0, RECIP_100};

    assign days = 32'(yy_reg) * 32'sd365 + 32'(yy_reg >>> 2) - 32'(cent_reg)
                  + 32'(cent_reg >>> 2) + $signed({23'd0, month_doy(mo_reg)})
                  + $signed({24'd0, dy_reg}) - 32'sd1 - EPOCH_DAYS;

    always_comb begin
        if (term_reg == 3'd0) begin
            term_mcand = 64'(days);
        end else if ({1'b0, seen_reg} > {1'b0, term_reg} + 4'd2) begin
            term_mcand = tv_reg[2'(term_reg - 3'd1)];
        end else begin
            term_mcand = 64'd0;
        end
    end

    assign yr_o = (seen_reg > 3'd0) ? yr_reg : 16'd0;
    assign mo_o = (seen_reg > 3'd1) ? mo_reg : 8'd0;
    assign dy_o = (seen_reg > 3'd2) ? dy_reg : 8'd0;

    always_comb begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        biv_next    = biv_reg;
        seen_next   = seen_reg;
        yr_next     = yr_reg;
        mo_next     = mo_reg;
        dy_next     = dy_reg;
        tv_next     = tv_reg;
        yy_next     = yy_reg;
        cent_next   = cent_reg;
        status_next = status_reg;
        term_next   = term_reg;
        mcand_next  = mcand_reg;
        scale_next  = scale_reg;
        ep_next     = ep_reg;
        mvalid_next = mvalid_reg && !m_axis_tready;
        mdata_next  = mdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (close_val) begin
                        if (seen_reg < 3'(MAX_VALUES)) begin
                            case (seen_reg)
                                3'd0:    yr_next = acc_or[15:0];
                                3'd1:    mo_next = acc_or[7:0];
                                3'd2:    dy_next = acc_or[7:0];
                                default: tv_next[2'(seen_reg - 3'd3)] = acc_or;
                            endcase
                            seen_next = seen_reg + 3'd1;
                        end
                        acc_next = 64'd0;
                        biv_next = 4'd0;
                    end else begin
                        acc_next = acc_or;
                        biv_next = biv_reg + 4'd1;
                    end
                    if (s_axis_tlast) begin
                        ep_next    = 64'd0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                yy_next   = $signed(yy_calc);
                cent_next = $signed(recip_prod[RECIP_SHIFT +: 11] - CENT_BIAS);
                term_next = 3'd0;
                if (seen_reg < 3'd3) begin
                    status_next = STATUS_SHORT;
                    state_next  = ST_FINISH;
                end else if (mo_reg < 8'd1 || mo_reg > 8'd12) begin
                    status_next = STATUS_BAD_MONTH;
                    state_next  = ST_FINISH;
                end else begin
                    status_next = STATUS_OK;
                    state_next  = ST_DAYS;
                end
            end
            ST_DAYS: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                mcand_next = term_mcand;
                scale_next = term_scale(term_reg);
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (scale_reg == 37'd0) begin
                    if (term_reg == 3'(NUM_TERMS - 1)) begin
                        state_next = ST_FINISH;
                    end else begin
                        term_next  = term_reg + 3'd1;
                        state_next = ST_LOAD;
                    end
                end else begin
                    if (scale_reg[0]) begin
                        ep_next = ep_reg + mcand_reg;
                    end
                    mcand_next = {mcand_reg[62:0], 1'b0};
                    scale_next = {1'b0, scale_reg[36:1]};
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {3'd0, status_reg, ep_reg, seen_reg, dy_o, mo_o, yr_o};
                    seen_next   = 3'd0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            acc_reg    <= 64'd0;
            biv_reg    <= 4'd0;
            seen_reg   <= 3'd0;
            mvalid_reg <= 1'b0;
            term_reg   <= 3'd0;
        end else begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            biv_reg    <= biv_next;
            seen_reg   <= seen_next;
            mvalid_reg <= mvalid_next;
            term_reg   <= term_next;
        end
    end

    always_ff @(posedge aclk) begin
        yr_reg     <= yr_next;
        mo_reg     <= mo_next;
        dy_reg     <= dy_next;
        tv_reg     <= tv_next;
        yy_reg     <= yy_next;
        cent_reg   <= cent_next;
        status_reg <= status_next;
        mcand_reg  <= mcand_next;
        scale_reg  <= scale_next;
        ep_reg     <= ep_next;
        mdata_reg  <= mdata_next;
    end

endmodule

/* rtl/vdtd_checker.sv */
// vdtd_checker: port-level assertions for varint_datetime_decoder_unit, bound into that module
// depends on vdtd_pkg

module vdtd_checker
    import vdtd_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [TDATA_OUT_W-1:0] m_axis_tdata
);

    logic [1:0]  st;
    logic [2:0]  cnt;
    logic [63:0] ep;

    assign st  = m_axis_tdata[100:99];
    assign cnt = m_axis_tdata[34:32];
    assign ep  = m_axis_tdata[98:35];

    // no result right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // error statuses carry a zero epoch
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && st != STATUS_OK |-> ep == 64'd0)
        else $error("nonzero epoch on error status");

    // the short status matches the value count
    a_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((cnt < 3'd3) == (st == STATUS_SHORT)))
        else $error("status and value count disagree");

    // a new result only follows a busy input side
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result while input side idle");

endmodule

bind varint_datetime_decoder_unit vdtd_checker u_vdtd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
